@@ hdl/inw_pkg.sv @@
// Shared types and constants for the identifier word normalizer.
package inw_pkg;

  localparam int unsigned CodeW = 8;

  localparam logic [CodeW-1:0] SpaceCode = 8'd32;
  localparam logic [CodeW-1:0] EmptyCode = 8'd0;
  localparam logic [CodeW-1:0] UpperA    = 8'd65;
  localparam logic [CodeW-1:0] UpperZ    = 8'd90;
  localparam logic [CodeW-1:0] LowerA    = 8'd97;
  localparam logic [CodeW-1:0] LowerZ    = 8'd122;
  localparam logic [CodeW-1:0] Digit0    = 8'd48;
  localparam logic [CodeW-1:0] Digit9    = 8'd57;
  localparam logic [CodeW-1:0] CaseStep  = 8'd32;

  // Classification of one raw byte.
  typedef struct packed {
    logic             upper;
    logic             lower;
    logic             word;
    logic [CodeW-1:0] folded;
  } char_class_t;

endpackage

@@ hdl/identifier_word_normalizer.sv @@
// Top level of the identifier word normalizer: input stage, word state, result register.
// An accepted item passes through the input stage and then the result register.
// Throughput: one item per cycle while the sink takes results; an item that needs an inserted
//   space first holds the input stage while the space goes out.
// Separators that cause no result are retired without output.
// Reset (rst_ni low, asynchronous) empties both stages and clears the word state.
module identifier_word_normalizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input byte stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] char_code
  input  logic                      s_axis_tlast,   // final_byte
  // Normalized byte stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] out_code
  output logic                      m_axis_tuser,   // [0] has_byte
  output logic                      m_axis_tlast    // end_of_name
);

  // Input stage
  logic                      in_valid_q, in_valid_d;
  logic [inw_pkg::CodeW-1:0] in_code_q;
  logic                      in_last_q;

  // Word state carried between bytes of one identifier
  logic prev_word_q,  prev_word_d;
  logic prev_lower_q, prev_lower_d;
  logic space_pend_q, space_pend_d;

  // Set once the inserted space of the current input item has been loaded into the result register
  logic phase_q, phase_d;

  // Result register
  logic                      out_valid_q, out_valid_d;
  logic [inw_pkg::CodeW-1:0] out_code_q,  out_code_d;
  logic                      out_has_q,   out_has_d;
  logic                      out_end_q,   out_end_d;

  inw_pkg::char_class_t cls;

  logic out_free;
  logic no_result;
  logic need_space;
  logic load_out;
  logic consume;
  logic accept_in;

  inw_classify u_classify (
    .code_i  (in_code_q),
    .class_o (cls)
  );

  // Result register can take a new item when empty or being drained this cycle.
  assign out_free = !out_valid_q || m_axis_tready;

  // A separator that is not the last byte only updates state.
  assign no_result = !cls.word && !in_last_q;

  // A word byte opens with a space after a separator run that follows a word byte, or on a camelCase step.
  assign need_space = cls.word && !phase_q &&
                      (space_pend_q || (cls.upper && prev_lower_q));

  assign load_out  = in_valid_q && !no_result && out_free;
  assign consume   = in_valid_q && (no_result || (out_free && !need_space));
  assign accept_in = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !in_valid_q || consume;

  always_comb begin
    in_valid_d   = in_valid_q;
    prev_word_d  = prev_word_q;
    prev_lower_d = prev_lower_q;
    space_pend_d = space_pend_q;
    phase_d      = phase_q;
    out_valid_d  = out_valid_q;
    out_code_d   = out_code_q;
    out_has_d    = out_has_q;
    out_end_d    = out_end_q;

    // Drop the result once the sink takes it.
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (load_out) begin
      out_valid_d = 1'b1;
      if (need_space) begin
        // Send the space first and hold the byte in the input stage.
        out_code_d = inw_pkg::SpaceCode;
        out_has_d  = 1'b1;
        out_end_d  = 1'b0;
        phase_d    = 1'b1;
      end else if (cls.word) begin
        out_code_d = cls.folded;
        out_has_d  = 1'b1;
        out_end_d  = in_last_q;
      end else begin
        // Separator as last byte: empty end marker, pending space is lost.
        out_code_d = inw_pkg::EmptyCode;
        out_has_d  = 1'b0;
        out_end_d  = 1'b1;
      end
    end

    if (consume) begin
      phase_d = 1'b0;
      if (in_last_q) begin
        prev_word_d  = 1'b0;
        prev_lower_d = 1'b0;
        space_pend_d = 1'b0;
      end else if (cls.word) begin
        prev_word_d  = 1'b1;
        prev_lower_d = cls.lower;
        space_pend_d = 1'b0;
      end else begin
        space_pend_d = space_pend_q || prev_word_q;
        prev_word_d  = 1'b0;
        prev_lower_d = 1'b0;
      end
    end

    // Advance the input stage.
    if (accept_in) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      prev_word_q  <= 1'b0;
      prev_lower_q <= 1'b0;
      space_pend_q <= 1'b0;
      phase_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      prev_word_q  <= prev_word_d;
      prev_lower_q <= prev_lower_d;
      space_pend_q <= space_pend_d;
      phase_q      <= phase_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      in_code_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    out_code_q <= out_code_d;
    out_has_q  <= out_has_d;
    out_end_q  <= out_end_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_code_q;
  assign m_axis_tuser  = out_has_q;
  assign m_axis_tlast  = out_end_q;

  // The space phase only exists while its byte waits in the input stage.
  a_phase_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> in_valid_q)
    else $error("space phase set with empty input stage");

  // A pending space always follows a separator, never a word byte.
  a_pend_not_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    space_pend_q |-> !prev_word_q)
    else $error("space pending right after a word byte");

  // An empty marker always closes the identifier.
  a_empty_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("empty marker without end of name");

  // An inserted space is never the final result.
  a_space_not_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser && (m_axis_tdata == inw_pkg::SpaceCode))
      |-> !m_axis_tlast)
    else $error("trailing space sent");

endmodule

@@ hdl/inw_classify.sv @@
// Byte classifier: letter/digit detection and lower-case folding.
module inw_classify (
  input  logic [inw_pkg::CodeW-1:0] code_i,
  output inw_pkg::char_class_t      class_o
);

  logic upper;
  logic lower;
  logic digit;

  assign upper = (code_i >= inw_pkg::UpperA) && (code_i <= inw_pkg::UpperZ);
  assign lower = (code_i >= inw_pkg::LowerA) && (code_i <= inw_pkg::LowerZ);
  assign digit = (code_i >= inw_pkg::Digit0) && (code_i <= inw_pkg::Digit9);

  always_comb begin
    class_o.upper  = upper;
    class_o.lower  = lower;
    class_o.word   = upper || lower || digit;
    class_o.folded = upper ? (code_i + inw_pkg::CaseStep) : code_i;
  end

endmodule
